[rtl/bbc_pkg.sv]
// shared types and constants for the byte budget two class cache
`timescale 1ns / 1ps
package bbc_pkg;
   localparam int unsigned ID_W   = 16;
   localparam int unsigned SIZE_W = 24;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_MOVE   = 2'd2,
      OP_FLUSH  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE    = 2'd0,
      ST_REFUSED = 2'd1,
      ST_ABSENT  = 2'd2
   } status_type;

   typedef enum logic [0:0] {
      KIND_EVICT    = 1'b0,
      KIND_COMPLETE = 1'b1
   } kind_type;

   typedef struct packed {
      op_type             op;
      logic [ID_W-1:0]    id;
      logic [SIZE_W-1:0]  size;
      logic               pre;
   } cmd_type;

   typedef struct packed {
      kind_type           kind;
      logic [ID_W-1:0]    id;
      status_type         status;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DYN_EVICT,
      S_PRE_EVICT,
      S_APPEND,
      S_SEARCH,
      S_SHIFT,
      S_FLUSH_DYN,
      S_FLUSH_PRE,
      S_COMPLETE
   } state_type;
endpackage

[rtl/byte_budget_two_class_fifo_cache_top.sv]
// top level of the byte budget two class fifo cache
`timescale 1ns / 1ps
// The engine takes one request at a time and walks the queues one entry per
// cycle, emitting at most one eviction per cycle, and compacts or appends in a
// step of its own. The longest case is an insert that evicts a full dynamic
// queue and then a full precache queue. A two entry queue decouples intake
// from the engine, so one or two requests can wait while the engine works.
// Responses leave through one output register; a stall there holds the walk.
// The budget register resets to zero, which refuses every insert.
module byte_budget_two_class_fifo_cache_top #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata,      // cache_budget
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,      // opcode[1:0], item_id[17:2], item_size[41:18]
   input  logic        req_tuser,      // precache_class
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,      // result_id[15:0], status[17:16]
   output logic        rsp_tuser,      // result_kind
   output logic        rsp_tlast       // last
);
   logic [bbc_pkg::SIZE_W-1:0] budget_ff;
   bbc_pkg::cmd_type in_cmd, q_cmd;
   bbc_pkg::rsp_type rsp;
   logic q_valid, q_ready;

   // budget register
   always_ff @(posedge clock) begin
      if (reset) budget_ff <= '0;
      else if (csr_we) budget_ff <= csr_wdata;
   end

   // front: unpack the request
   assign in_cmd = '{op: bbc_pkg::op_type'(req_tdata[1:0]), id: req_tdata[17:2],
                     size: req_tdata[41:18], pre: req_tuser};

   bbc_cmd_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_cmd(in_cmd),
      .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
   );

   // back: carry out the request
   bbc_engine #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_engine (
      .clock, .reset, .budget(budget_ff),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {6'b0, rsp.status, rsp.id};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;
endmodule

[rtl/bbc_cmd_queue.sv]
// two entry request queue between intake and engine
`timescale 1ns / 1ps
module bbc_cmd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  bbc_pkg::cmd_type in_cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output bbc_pkg::cmd_type out_cmd
);
   bbc_pkg::cmd_type slot_ff [2];
   logic             wr_ff, rd_ff, wr_in, rd_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_cmd   = slot_ff[rd_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) slot_ff[wr_ff] <= in_cmd;
   end
endmodule

[rtl/bbc_engine.sv]
// queue engine: evicts, searches, compacts and reports one step a cycle unless the output stalls
`timescale 1ns / 1ps
module bbc_engine #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [bbc_pkg::SIZE_W-1:0]  budget,
   input  logic                        cmd_valid,
   output logic                        cmd_ready,
   input  bbc_pkg::cmd_type            cmd,
   output logic                        out_valid,
   input  logic                        out_ready,
   output bbc_pkg::rsp_type            out_rsp
);
   localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL = CW'(QUEUE_DEPTH);

   // entries, oldest at slot 0; index 0 = dynamic, 1 = precache
   logic [bbc_pkg::ID_W-1:0]   ids_ff   [2][QUEUE_DEPTH];
   logic [bbc_pkg::SIZE_W-1:0] sizes_ff [2][QUEUE_DEPTH];
   logic [CW-1:0]              cnt_ff [2], cnt_in [2];
   logic [bbc_pkg::SIZE_W-1:0] tot_ff [2], tot_in [2];

   bbc_pkg::state_type  state_ff, state_in;
   bbc_pkg::cmd_type    cur_ff, cur_in;
   bbc_pkg::status_type st_ff, st_in;
   logic [CW-1:0]       pos_ff, pos_in;
   logic                q_ff, q_in;       // queue under search or shift
   logic                mv_ff, mv_in;     // shift is a move
   logic [bbc_pkg::SIZE_W-1:0] msz_ff, msz_in;
   bbc_pkg::rsp_type    rsp_ff, rsp_in;
   logic                ov_ff, ov_in;

   // shift control for this cycle
   logic          do_shift, do_app;
   logic          sh_q, ap_q;
   logic [IW-1:0] sh_pos;
   logic [bbc_pkg::ID_W-1:0]   ap_id;
   logic [bbc_pkg::SIZE_W-1:0] ap_sz;

   logic [bbc_pkg::SIZE_W+1:0] sum_all, sum_pre;
   logic can_emit, fits_all, fits_pre;
   logic [IW-1:0] pidx;

   assign pidx    = pos_ff[IW-1:0];
   assign sum_all = {2'b0, tot_ff[0]} + {2'b0, tot_ff[1]} + {2'b0, cur_ff.size};
   assign sum_pre = {2'b0, tot_ff[1]} + {2'b0, cur_ff.size};
   assign fits_all = (sum_all <= {2'b0, budget});
   assign fits_pre = (sum_pre <= {2'b0, budget});
   assign can_emit = !ov_ff || out_ready;
   assign cmd_ready = (state_ff == bbc_pkg::S_IDLE);
   assign out_valid = ov_ff;
   assign out_rsp   = rsp_ff;

   function automatic logic [bbc_pkg::SIZE_W-1:0] sub_sat(
      input logic [bbc_pkg::SIZE_W-1:0] a, input logic [bbc_pkg::SIZE_W-1:0] b);
      return (a >= b) ? a - b : '0;
   endfunction

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bbc_pkg::S_IDLE:
            if (cmd_valid) begin
               unique case (cmd.op)
                  bbc_pkg::OP_INSERT:
                     state_in = (budget == '0 || cmd.size > budget) ?
                                bbc_pkg::S_COMPLETE : bbc_pkg::S_DYN_EVICT;
                  bbc_pkg::OP_REMOVE, bbc_pkg::OP_MOVE: state_in = bbc_pkg::S_SEARCH;
                  bbc_pkg::OP_FLUSH: state_in = bbc_pkg::S_FLUSH_DYN;
                  default: state_in = bbc_pkg::S_IDLE;
               endcase
            end
         bbc_pkg::S_DYN_EVICT:
            if (cnt_ff[0] == '0 || fits_all)
               state_in = (cnt_ff[0] == '0 && cur_ff.pre) ?
                          bbc_pkg::S_PRE_EVICT : bbc_pkg::S_APPEND;
         bbc_pkg::S_PRE_EVICT:
            if (cnt_ff[1] == '0 || fits_pre) state_in = bbc_pkg::S_APPEND;
         bbc_pkg::S_APPEND: state_in = bbc_pkg::S_COMPLETE;
         bbc_pkg::S_SEARCH:
            if (pos_ff < cnt_ff[q_ff] && ids_ff[q_ff][pidx] == cur_ff.id)
               state_in = (mv_ff && cnt_ff[1] >= FULL) ?
                          bbc_pkg::S_COMPLETE : bbc_pkg::S_SHIFT;
            else if (pos_ff >= cnt_ff[q_ff] &&
                     (q_ff || cur_ff.op == bbc_pkg::OP_MOVE))
               state_in = bbc_pkg::S_COMPLETE;
         bbc_pkg::S_SHIFT: state_in = bbc_pkg::S_COMPLETE;
         bbc_pkg::S_FLUSH_DYN:
            if (pos_ff >= cnt_ff[0]) state_in = bbc_pkg::S_FLUSH_PRE;
         bbc_pkg::S_FLUSH_PRE:
            if (pos_ff >= cnt_ff[1]) state_in = bbc_pkg::S_COMPLETE;
         bbc_pkg::S_COMPLETE:
            if (can_emit) state_in = bbc_pkg::S_IDLE;
         default: state_in = bbc_pkg::S_IDLE;
      endcase
      // eviction and flush steps wait for a free output slot
      if ((state_ff == bbc_pkg::S_DYN_EVICT || state_ff == bbc_pkg::S_PRE_EVICT ||
           state_ff == bbc_pkg::S_FLUSH_DYN || state_ff == bbc_pkg::S_FLUSH_PRE) &&
          !can_emit)
         state_in = state_ff;
   end

   // datapath
   always_comb begin
      cur_in = cur_ff; st_in = st_ff; pos_in = pos_ff; q_in = q_ff;
      mv_in = mv_ff; msz_in = msz_ff; rsp_in = rsp_ff;
      ov_in = ov_ff && !out_ready;
      cnt_in[0] = cnt_ff[0]; cnt_in[1] = cnt_ff[1];
      tot_in[0] = tot_ff[0]; tot_in[1] = tot_ff[1];
      do_shift = 1'b0; do_app = 1'b0; sh_q = 1'b0; ap_q = 1'b0;
      sh_pos = '0; ap_id = cur_ff.id; ap_sz = cur_ff.size;
      unique case (state_ff)
         bbc_pkg::S_IDLE:
            if (cmd_valid) begin
               cur_in = cmd;
               st_in  = (cmd.op == bbc_pkg::OP_INSERT &&
                         (budget == '0 || cmd.size > budget)) ?
                        bbc_pkg::ST_REFUSED : bbc_pkg::ST_DONE;
               pos_in = '0;
               q_in   = 1'b0;
               mv_in  = (cmd.op == bbc_pkg::OP_MOVE);
            end
         bbc_pkg::S_DYN_EVICT, bbc_pkg::S_PRE_EVICT: begin
            sh_q = (state_ff == bbc_pkg::S_PRE_EVICT);
            if (can_emit && cnt_ff[sh_q] != '0 &&
                !(sh_q ? fits_pre : fits_all)) begin
               rsp_in = '{kind: bbc_pkg::KIND_EVICT, id: ids_ff[sh_q][0],
                          status: bbc_pkg::ST_DONE, last: 1'b0};
               ov_in = 1'b1;
               do_shift = 1'b1;
               cnt_in[sh_q] = cnt_ff[sh_q] - 1'b1;
               tot_in[sh_q] = (cnt_ff[sh_q] == CW'(1)) ? '0 :
                              sub_sat(tot_ff[sh_q], sizes_ff[sh_q][0]);
            end
         end
         bbc_pkg::S_APPEND: begin
            ap_q = cur_ff.pre;
            if (!fits_all || cnt_ff[ap_q] >= FULL) st_in = bbc_pkg::ST_REFUSED;
            else begin
               do_app = 1'b1;
               cnt_in[ap_q] = cnt_ff[ap_q] + 1'b1;
               tot_in[ap_q] = tot_ff[ap_q] + cur_ff.size;
            end
         end
         bbc_pkg::S_SEARCH:
            if (pos_ff < cnt_ff[q_ff] && ids_ff[q_ff][pidx] == cur_ff.id) begin
               msz_in = sizes_ff[q_ff][pidx];
               if (mv_ff && cnt_ff[1] >= FULL) st_in = bbc_pkg::ST_REFUSED;
            end else if (pos_ff >= cnt_ff[q_ff]) begin
               if (q_ff || cur_ff.op == bbc_pkg::OP_MOVE) st_in = bbc_pkg::ST_ABSENT;
               else begin
                  q_in = 1'b1;
                  pos_in = '0;
               end
            end else pos_in = pos_ff + 1'b1;
         bbc_pkg::S_SHIFT: begin
            do_shift = 1'b1; sh_q = q_ff; sh_pos = pidx;
            cnt_in[q_ff] = cnt_ff[q_ff] - 1'b1;
            tot_in[q_ff] = sub_sat(tot_ff[q_ff], msz_ff);
            if (mv_ff) begin
               do_app = 1'b1; ap_q = 1'b1; ap_sz = msz_ff;
               cnt_in[1] = cnt_ff[1] + 1'b1;
               tot_in[1] = tot_ff[1] + msz_ff;
            end
         end
         bbc_pkg::S_FLUSH_DYN, bbc_pkg::S_FLUSH_PRE: begin
            sh_q = (state_ff == bbc_pkg::S_FLUSH_PRE);
            if (can_emit) begin
               if (pos_ff < cnt_ff[sh_q]) begin
                  rsp_in = '{kind: bbc_pkg::KIND_EVICT, id: ids_ff[sh_q][pidx],
                             status: bbc_pkg::ST_DONE, last: 1'b0};
                  ov_in = 1'b1;
                  pos_in = pos_ff + 1'b1;
               end else begin
                  pos_in = '0;
                  if (sh_q) begin
                     cnt_in[0] = '0; cnt_in[1] = '0;
                     tot_in[0] = '0; tot_in[1] = '0;
                     cur_in.id = '0;
                  end
               end
            end
         end
         bbc_pkg::S_COMPLETE:
            if (can_emit) begin
               rsp_in = '{kind: bbc_pkg::KIND_COMPLETE, id: cur_ff.id,
                          status: st_ff, last: 1'b1};
               ov_in = 1'b1;
            end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bbc_pkg::S_IDLE;
         ov_ff    <= 1'b0;
         cnt_ff[0] <= '0; cnt_ff[1] <= '0;
         tot_ff[0] <= '0; tot_ff[1] <= '0;
      end else begin
         state_ff <= state_in;
         ov_ff    <= ov_in;
         cnt_ff[0] <= cnt_in[0]; cnt_ff[1] <= cnt_in[1];
         tot_ff[0] <= tot_in[0]; tot_ff[1] <= tot_in[1];
      end
      cur_ff <= cur_in; st_ff <= st_in; pos_ff <= pos_in; q_ff <= q_in;
      mv_ff <= mv_in; msz_ff <= msz_in; rsp_ff <= rsp_in;
      // compaction: slots at and above sh_pos take their upper neighbor
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
         if (do_shift && IW'(i) >= sh_pos) begin
            ids_ff[sh_q][i]   <= ids_ff[sh_q][i+1];
            sizes_ff[sh_q][i] <= sizes_ff[sh_q][i+1];
         end
      end
      if (do_app) begin
         ids_ff[ap_q][cnt_ff[ap_q][IW-1:0] - IW'(do_shift && sh_q == ap_q)] <= ap_id;
         sizes_ff[ap_q][cnt_ff[ap_q][IW-1:0] - IW'(do_shift && sh_q == ap_q)] <= ap_sz;
      end
   end
endmodule

[rtl/bbc_checker.sv]
// port level checks for the cache top, bound to the top level
`timescale 1ns / 1ps
module bbc_port_checks (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tlast == rsp_tuser)
      else $error("last differs from completion kind");
   a_evict_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[17:16] == 2'd0)
      else $error("eviction with nonzero status");
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[17:16] != 2'd3)
      else $error("status code out of range");
endmodule

bind byte_budget_two_class_fifo_cache_top bbc_port_checks u_bbc_port_checks (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
);

[sim/bbc_checker.sv]
// checker that predicts cache responses and compares them on the response channel
`timescale 1ns / 1ps
module bbc_checker
   import bbc_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [23:0] csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,
   input  logic        rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending_count,
   output int          evict_seen,
   output int          done_seen
);
   typedef struct {
      kind_type   kind;
      logic [15:0] id;
      status_type status;
      logic       last;
   } result_type;

   logic [23:0] budget;
   logic [15:0] dyn_ids[$];
   logic [23:0] dyn_sizes[$];
   logic [23:0] dyn_total;
   logic [15:0] pre_ids[$];
   logic [23:0] pre_sizes[$];
   logic [23:0] pre_total;
   result_type  expected_rsp[$];

   function automatic logic [23:0] sat_sub(logic [23:0] a, logic [23:0] b);
      return (a >= b) ? a - b : 24'd0;
   endfunction

   function automatic int find_in(ref logic [15:0] ids[$], input logic [15:0] id);
      foreach (ids[i]) if (ids[i] == id) return i;
      return -1;
   endfunction

   task automatic push_rsp(kind_type k, logic [15:0] id, status_type st, logic l);
      result_type r;
      r.kind = k; r.id = id; r.status = st; r.last = l;
      expected_rsp.push_back(r);
   endtask

   // works out the responses of one request and updates the cache image
   task automatic predict_cache(op_type op, logic [15:0] id, logic [23:0] sz, logic pre);
      status_type st;
      int pos;
      logic [23:0] msz;
      st = ST_DONE;
      case (op)
         OP_INSERT: begin
            if (budget == 0 || sz > budget) st = ST_REFUSED;
            else begin
               while (dyn_ids.size() > 0 &&
                      ({24'd0, dyn_total} + pre_total + sz) > {24'd0, budget}) begin
                  push_rsp(KIND_EVICT, dyn_ids[0], ST_DONE, 1'b0);
                  dyn_total = sat_sub(dyn_total, dyn_sizes[0]);
                  void'(dyn_ids.pop_front()); void'(dyn_sizes.pop_front());
                  if (dyn_ids.size() == 0) dyn_total = 0;
               end
               if (dyn_ids.size() == 0 && pre) begin
                  while (pre_ids.size() > 0 &&
                         ({24'd0, pre_total} + sz) > {24'd0, budget}) begin
                     push_rsp(KIND_EVICT, pre_ids[0], ST_DONE, 1'b0);
                     pre_total = sat_sub(pre_total, pre_sizes[0]);
                     void'(pre_ids.pop_front()); void'(pre_sizes.pop_front());
                     if (pre_ids.size() == 0) pre_total = 0;
                  end
               end
               if (({24'd0, dyn_total} + pre_total + sz) > {24'd0, budget}) st = ST_REFUSED;
               else if (pre) begin
                  if (pre_ids.size() >= QUEUE_DEPTH) st = ST_REFUSED;
                  else begin
                     pre_ids.push_back(id); pre_sizes.push_back(sz);
                     pre_total = pre_total + sz;
                  end
               end else begin
                  if (dyn_ids.size() >= QUEUE_DEPTH) st = ST_REFUSED;
                  else begin
                     dyn_ids.push_back(id); dyn_sizes.push_back(sz);
                     dyn_total = dyn_total + sz;
                  end
               end
            end
            push_rsp(KIND_COMPLETE, id, st, 1'b1);
         end
         OP_REMOVE: begin
            pos = find_in(dyn_ids, id);
            if (pos >= 0) begin
               dyn_total = sat_sub(dyn_total, dyn_sizes[pos]);
               dyn_ids.delete(pos); dyn_sizes.delete(pos);
            end else begin
               pos = find_in(pre_ids, id);
               if (pos >= 0) begin
                  pre_total = sat_sub(pre_total, pre_sizes[pos]);
                  pre_ids.delete(pos); pre_sizes.delete(pos);
               end else st = ST_ABSENT;
            end
            push_rsp(KIND_COMPLETE, id, st, 1'b1);
         end
         OP_MOVE: begin
            pos = find_in(dyn_ids, id);
            if (pos < 0) st = ST_ABSENT;
            else if (pre_ids.size() >= QUEUE_DEPTH) st = ST_REFUSED;
            else begin
               msz = dyn_sizes[pos];
               pre_ids.push_back(id); pre_sizes.push_back(msz);
               pre_total = pre_total + msz;
               dyn_total = sat_sub(dyn_total, msz);
               dyn_ids.delete(pos); dyn_sizes.delete(pos);
            end
            push_rsp(KIND_COMPLETE, id, st, 1'b1);
         end
         default: begin
            foreach (dyn_ids[i]) push_rsp(KIND_EVICT, dyn_ids[i], ST_DONE, 1'b0);
            foreach (pre_ids[i]) push_rsp(KIND_EVICT, pre_ids[i], ST_DONE, 1'b0);
            dyn_ids.delete(); dyn_sizes.delete(); pre_ids.delete(); pre_sizes.delete();
            dyn_total = 0; pre_total = 0;
            push_rsp(KIND_COMPLETE, 16'd0, ST_DONE, 1'b1);
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         budget = 24'd0;
         dyn_ids.delete(); dyn_sizes.delete(); pre_ids.delete(); pre_sizes.delete();
         dyn_total = 0; pre_total = 0;
         expected_rsp.delete();
         fail_count <= 0; evict_seen <= 0; done_seen <= 0;
      end else begin
         if (csr_we) budget = csr_wdata;
         if (req_tvalid && req_tready)
            predict_cache(op_type'(req_tdata[1:0]), req_tdata[17:2], req_tdata[41:18],
                          req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: response with none expected: id %h kind %b", $time,
                        rsp_tdata[15:0], rsp_tuser);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tuser !== want.kind || rsp_tdata[15:0] !== want.id ||
                   rsp_tdata[17:16] !== want.status || rsp_tlast !== want.last ||
                   rsp_tdata[23:18] !== 6'd0) begin
                  $display("%0t: mismatch expected kind %0d id %h status %0d last %0d",
                           $time, want.kind, want.id, want.status, want.last);
                  $display("%0t:          actual kind %0d id %h status %0d last %0d",
                           $time, rsp_tuser, rsp_tdata[15:0], rsp_tdata[17:16], rsp_tlast);
                  fail_count <= fail_count + 1;
               end
               if (want.kind == KIND_EVICT) evict_seen <= evict_seen + 1;
               else done_seen <= done_seen + 1;
            end
         end
      end
   end

   assign pending_count = expected_rsp.size();
endmodule

[sim/tb_top.sv]
// testbench top: request stimulus, budget phases and the verdict
`timescale 1ns / 1ps
module tb_top;
   import bbc_pkg::*;

   localparam int unsigned DEPTH = 16;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [23:0] csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;       // opcode[1:0], item_id[17:2], item_size[41:18]
   logic        req_tuser = 1'b0;     // precache_class
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;            // result_id[15:0], status[17:16]
   logic        rsp_tuser;            // result_kind
   logic        rsp_tlast;
   int          fail_count, pending_count, evict_seen, done_seen;

   // receiver controls
   bit          sink_quiet = 1'b0;    // no idling on the response side
   int          hold_cycles = 0;      // long back-pressure request
   int          sent_count = 0;
   logic [15:0] recent_ids[$];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   byte_budget_two_class_fifo_cache_top #(.QUEUE_DEPTH(DEPTH)) dut (.*);

   bbc_checker #(.QUEUE_DEPTH(DEPTH)) checker_i (.*);

   // response side: random stalls, plus a long hold when asked
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         rsp_tready  <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else rsp_tready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 18);
   end

   // offer one request and wait for the handshake; tvalid stays high afterwards
   task automatic send_req(op_type op, logic [15:0] id, logic [23:0] sz, logic pre,
                           bit gaps);
      if (gaps) begin
         while ($urandom_range(99) < 18) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, sz, id, op};
      req_tuser  <= pre;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_count++;
      recent_ids.push_back(id);
      if (recent_ids.size() > 24) void'(recent_ids.pop_front());
   endtask

   // stop offering, wait until idle, then write the budget
   task automatic drain_then_set(logic [23:0] value);
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   function automatic logic [15:0] pick_id();
      if (recent_ids.size() > 0 && $urandom_range(99) < 65)
         return recent_ids[$urandom_range(recent_ids.size() - 1)];
      return 16'($urandom_range(63));
   endfunction

   task automatic random_phase(int count, logic [23:0] budget, bit gaps);
      int   pct;
      op_type op;
      logic [23:0] sz;
      for (int n = 0; n < count; n++) begin
         pct = $urandom_range(99);
         op  = pct < 55 ? OP_INSERT : pct < 75 ? OP_REMOVE : pct < 93 ? OP_MOVE : OP_FLUSH;
         // sizes mostly a fraction of the budget so queues fill and evict
         if ($urandom_range(9) == 0) sz = 24'($urandom);
         else if (budget == 0) sz = 24'($urandom_range(255));
         else sz = 24'($urandom_range(budget / 6 + 1));
         send_req(op, ($urandom_range(19) == 0) ? 16'($urandom) : pick_id(), sz,
                  $urandom_range(1), gaps);
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled cache: budget still zero, inserts refused
      send_req(OP_INSERT, 16'h0001, 24'd1, 1'b0, 1'b0);
      send_req(OP_REMOVE, 16'hFFFF, 24'hFFFFFF, 1'b1, 1'b0);
      send_req(OP_MOVE, 16'h0000, 24'd0, 1'b0, 1'b0);
      send_req(OP_FLUSH, 16'hABCD, 24'd0, 1'b0, 1'b0);

      // small budget: eviction order, duplicates, move, full queue
      drain_then_set(24'd100);
      send_req(OP_INSERT, 16'd10, 24'd101, 1'b0, 1'b0);   // larger than budget
      send_req(OP_INSERT, 16'd10, 24'd40, 1'b0, 1'b0);
      send_req(OP_INSERT, 16'd10, 24'd30, 1'b0, 1'b0);    // duplicate id
      send_req(OP_INSERT, 16'd11, 24'd30, 1'b1, 1'b0);
      send_req(OP_MOVE, 16'd10, 24'd0, 1'b0, 1'b0);       // oldest match moves
      send_req(OP_MOVE, 16'd11, 24'd0, 1'b0, 1'b0);       // not in dynamic
      send_req(OP_INSERT, 16'd12, 24'd100, 1'b1, 1'b0);   // evicts dynamic then precache
      send_req(OP_INSERT, 16'd13, 24'd50, 1'b0, 1'b0);    // does not fit, precache is not evicted
      send_req(OP_REMOVE, 16'd12, 24'd0, 1'b0, 1'b0);
      send_req(OP_REMOVE, 16'd12, 24'd0, 1'b0, 1'b0);     // no longer held
      for (int i = 0; i < DEPTH + 1; i++)                 // last one hits a full queue
         send_req(OP_INSERT, 16'(i), 24'd0, 1'b1, 1'b0);
      send_req(OP_INSERT, 16'd99, 24'd1, 1'b0, 1'b0);
      send_req(OP_MOVE, 16'd99, 24'd0, 1'b0, 1'b0);       // precache full
      send_req(OP_FLUSH, 16'd0, 24'd0, 1'b0, 1'b0);

      // largest budget with random traffic, no idling first
      drain_then_set(24'hFFFFFF);
      sink_quiet = 1'b1;
      random_phase(40, 24'hFFFFFF, 1'b0);
      sink_quiet = 1'b0;

      // long receiver hold while requests keep coming
      hold_cycles = 300;
      random_phase(30, 24'hFFFFFF, 1'b0);

      // lowered budget: the next inserts do the eviction
      drain_then_set(24'd500);
      random_phase(60, 24'd500, 1'b1);
      drain_then_set(24'd1);
      random_phase(25, 24'd1, 1'b1);
      drain_then_set(24'd0);
      random_phase(10, 24'd0, 1'b1);
      drain_then_set(24'd5000);
      random_phase(60, 24'd5000, 1'b1);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (2 * DEPTH + 10) @(posedge clock);
      $display("covered %0d requests over six budgets including zero and full scale,",
               sent_count);
      $display("%0d evictions and %0d completions checked", evict_seen, done_seen);
      if (fail_count == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

   // timeout well beyond the slowest correct run
   initial begin
      #4000000;
      $display("status: fail");
      $finish;
   end
endmodule
